// ===== rtl/core/nmea_sentence_parser_unit_assert.svh =====
// assertion macros shared by nsp_front and nsp_queue
`ifndef NMEA_SENTENCE_PARSER_UNIT_ASSERT_SVH
`define NMEA_SENTENCE_PARSER_UNIT_ASSERT_SVH

// condition must never hold outside reset
`define NSP_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("nsp: forbidden condition");

// antecedent in one cycle implies consequent in the next
`define NSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsp: sequence violated");

`endif

// ===== rtl/core/nsp_pkg.sv =====
`default_nettype none
package nsp_pkg;

  localparam int unsigned COORD_FRAC_DIGITS_DEF = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_A      = 8'h41;

  localparam logic [1:0] TM_RMC = 2'd1;
  localparam logic [1:0] TM_GGA = 2'd2;
  localparam logic [1:0] TM_ANY = 2'd3;

  localparam logic [11:0] YEAR_BASE = 12'd2000;

  typedef enum logic [1:0] {
    PH_BODY = 2'd0,
    PH_HEX1 = 2'd1,
    PH_HEX2 = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    RL_NONE, RL_TIME, RL_STATUS, RL_LAT, RL_NS, RL_LON, RL_EW,
    RL_SLOTA, RL_SLOTB, RL_DATE, RL_QUAL, RL_SATS
  } role_t;

  // raw sentence record handed from the parser to the formatter
  typedef struct packed {
    logic        gga;
    logic        fix;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [16:0] second_milli;
    logic        south;
    logic [29:0] lat_mag;
    logic        west;
    logic [30:0] lon_mag;
    logic [26:0] slot_a;
    logic        slot_b_neg;
    logic [26:0] slot_b;
    logic [6:0]  day_sats;
    logic [6:0]  month;
    logic [6:0]  year2;
  } record_t;

  function automatic role_t nsp_role(input logic [1:0] tm, input logic [3:0] fn);
    role_t r;
    r = RL_NONE;
    if (tm == TM_RMC) begin
      unique case (fn)
        4'd1: r = RL_TIME;
        4'd2: r = RL_STATUS;
        4'd3: r = RL_LAT;
        4'd4: r = RL_NS;
        4'd5: r = RL_LON;
        4'd6: r = RL_EW;
        4'd7: r = RL_SLOTA;
        4'd8: r = RL_SLOTB;
        4'd9: r = RL_DATE;
        default: r = RL_NONE;
      endcase
    end else if (tm == TM_GGA) begin
      unique case (fn)
        4'd1: r = RL_TIME;
        4'd2: r = RL_LAT;
        4'd3: r = RL_NS;
        4'd4: r = RL_LON;
        4'd5: r = RL_EW;
        4'd6: r = RL_QUAL;
        4'd7: r = RL_SATS;
        4'd8: r = RL_SLOTA;
        4'd9: r = RL_SLOTB;
        default: r = RL_NONE;
      endcase
    end
    return r;
  endfunction

  function automatic logic [19:0] nsp_pow10(input logic [2:0] e);
    logic [19:0] p;
    unique case (e)
      3'd0: p = 20'd1;
      3'd1: p = 20'd10;
      3'd2: p = 20'd100;
      3'd3: p = 20'd1000;
      3'd4: p = 20'd10000;
      3'd5: p = 20'd100000;
      3'd6: p = 20'd1000000;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] nsp_name_char(input logic gga, input logic [2:0] p);
    logic [7:0] ch;
    unique case (p)
      3'd0: ch = 8'h47;
      3'd1: ch = 8'h50;
      3'd2: ch = gga ? 8'h47 : 8'h52;
      3'd3: ch = gga ? 8'h47 : 8'h4D;
      3'd4: ch = gga ? 8'h41 : 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // bit 4 flags a character that is not a hex digit
  function automatic logic [4:0] nsp_hex(input logic [7:0] c);
    logic [4:0] h;
    if (c >= 8'h30 && c <= 8'h39) h = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      h = {1'b0, c[3:0] + 4'd9};
    else h = 5'h10;
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nmea_sentence_parser_unit.sv =====
`default_nettype none
// Character-at-a-time NMEA sentence parser for recommended-minimum and fix-data
// sentences. One character is taken per clock whenever full is low; full rises
// only when both records in the internal queue and the output register are
// occupied by unread sentences. Every character is parsed by combinational logic
// (one decimal accumulate, or one field scale multiply at a comma or '*') into
// registered state, and a validated sentence reaches the result ports through a
// two-entry queue and an output register.
module nmea_sentence_parser_unit #(
  parameter int unsigned COORD_FRAC_DIGITS = nsp_pkg::COORD_FRAC_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         char_byte,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    sentence_kind,
  output logic                    position_fix,
  output logic [6:0]              hour,
  output logic [6:0]              minute,
  output logic [16:0]             second_milli,
  output logic signed [30:0]      latitude,
  output logic signed [31:0]      longitude,
  output logic [26:0]             speed_or_hdop,
  output logic signed [27:0]      course_or_altitude,
  output logic [6:0]              day_or_satellites,
  output logic [6:0]              month,
  output logic [11:0]             year
);
  import nsp_pkg::*;

  logic    emit, q_empty, q_pop;
  record_t rec, q_data;

  nsp_front #(.COORD_FRAC_DIGITS(COORD_FRAC_DIGITS)) u_front (
    .clk(clk), .rst(rst), .take(push && !full), .char_byte(char_byte),
    .emit(emit), .rec(rec)
  );

  nsp_queue u_queue (
    .clk(clk), .rst(rst), .push(emit), .wdata(rec), .full(full),
    .pop(q_pop), .empty(q_empty), .rdata(q_data)
  );

  nsp_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .empty(empty), .pop(pop),
    .sentence_kind(sentence_kind), .position_fix(position_fix),
    .hour(hour), .minute(minute), .second_milli(second_milli),
    .latitude(latitude), .longitude(longitude),
    .speed_or_hdop(speed_or_hdop), .course_or_altitude(course_or_altitude),
    .day_or_satellites(day_or_satellites), .month(month), .year(year)
  );
endmodule
`default_nettype wire

// ===== rtl/core/nsp_front.sv =====
`default_nettype none
`include "nmea_sentence_parser_unit_assert.svh"
module nsp_front #(
  parameter int unsigned COORD_FRAC_DIGITS = nsp_pkg::COORD_FRAC_DIGITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       char_byte,
  output logic                  emit,
  output nsp_pkg::record_t      rec
);
  import nsp_pkg::*;

  localparam logic [2:0] COORD_LIM = 3'(COORD_FRAC_DIGITS);

  logic        active, active_next;
  phase_t      phase, phase_next;
  logic [7:0]  rxor, rxor_next;
  logic [7:0]  rsum, rsum_next;
  logic        herr, herr_next;
  logic [3:0]  fn, fn_next;
  logic [4:0]  cif, cif_next;
  logic [1:0]  tm, tm_next;
  logic [31:0] acc, acc_next;
  logic [2:0]  fd, fd_next;
  logic        pt, pt_next;
  logic [6:0]  hour, hour_next, minute, minute_next;
  logic [16:0] sec, sec_next;
  logic [6:0]  day, day_next, month, month_next, yr, yr_next;
  logic        stat_a, stat_a_next, south, south_next, west, west_next;
  logic        qual, qual_next;
  logic [29:0] lat, lat_next;
  logic [30:0] lon, lon_next;
  logic [26:0] sla, sla_next, slb, slb_next;
  logic [6:0]  sats, sats_next;
  logic        altneg, altneg_next, minus, minus_next;

  role_t       role;
  logic [2:0]  flim, fd_eff;
  logic [51:0] prod;
  logic [35:0] acc_step;
  logic        is_digit, do_finish;
  logic [3:0]  dig;
  logic [4:0]  hx;
  logic [7:0]  c;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      phase  <= PH_BODY;
      rxor   <= '0;
      rsum   <= '0;
      herr   <= 1'b0;
      fn     <= '0;
      cif    <= '0;
      tm     <= '0;
      acc    <= '0;
      fd     <= '0;
      pt     <= 1'b0;
      hour   <= '0;
      minute <= '0;
      sec    <= '0;
      day    <= '0;
      month  <= '0;
      yr     <= '0;
      stat_a <= 1'b0;
      south  <= 1'b0;
      west   <= 1'b0;
      qual   <= 1'b0;
      lat    <= '0;
      lon    <= '0;
      sla    <= '0;
      slb    <= '0;
      sats   <= '0;
      altneg <= 1'b0;
      minus  <= 1'b0;
    end else begin
      active <= active_next;
      phase  <= phase_next;
      rxor   <= rxor_next;
      rsum   <= rsum_next;
      herr   <= herr_next;
      fn     <= fn_next;
      cif    <= cif_next;
      tm     <= tm_next;
      acc    <= acc_next;
      fd     <= fd_next;
      pt     <= pt_next;
      hour   <= hour_next;
      minute <= minute_next;
      sec    <= sec_next;
      day    <= day_next;
      month  <= month_next;
      yr     <= yr_next;
      stat_a <= stat_a_next;
      south  <= south_next;
      west   <= west_next;
      qual   <= qual_next;
      lat    <= lat_next;
      lon    <= lon_next;
      sla    <= sla_next;
      slb    <= slb_next;
      sats   <= sats_next;
      altneg <= altneg_next;
      minus  <= minus_next;
    end
  end

  always_comb begin
    c        = char_byte;
    role     = nsp_role(tm, fn);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
    dig      = c[3:0];
    hx       = nsp_hex(c);
    if (role == RL_LAT || role == RL_LON) flim = COORD_LIM;
    else if (role == RL_QUAL || role == RL_SATS) flim = 3'd0;
    else flim = 3'd3;
    fd_eff   = (fd > flim) ? flim : fd;
    prod     = {20'd0, acc} * {32'd0, nsp_pow10(flim - fd_eff)};
    acc_step = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, dig};

    active_next = active;  phase_next = phase;  rxor_next = rxor;
    rsum_next = rsum;      herr_next = herr;    fn_next = fn;
    cif_next = cif;        tm_next = tm;        acc_next = acc;
    fd_next = fd;          pt_next = pt;        hour_next = hour;
    minute_next = minute;  sec_next = sec;      day_next = day;
    month_next = month;    yr_next = yr;        stat_a_next = stat_a;
    south_next = south;    west_next = west;    qual_next = qual;
    lat_next = lat;        lon_next = lon;      sla_next = sla;
    slb_next = slb;        sats_next = sats;    altneg_next = altneg;
    minus_next = minus;
    emit = 1'b0;
    do_finish = 1'b0;

    if (take && c != CH_CR && c != CH_LF) begin
      if (c == CH_DOLLAR) begin
        active_next = 1'b1;  phase_next = PH_BODY;  rxor_next = '0;
        rsum_next = '0;      herr_next = 1'b0;      fn_next = '0;
        cif_next = '0;       tm_next = TM_ANY;      acc_next = '0;
        fd_next = '0;        pt_next = 1'b0;        hour_next = '0;
        minute_next = '0;    sec_next = '0;         day_next = '0;
        month_next = '0;     yr_next = '0;          stat_a_next = 1'b0;
        south_next = 1'b0;   west_next = 1'b0;      qual_next = 1'b0;
        lat_next = '0;       lon_next = '0;         sla_next = '0;
        slb_next = '0;       sats_next = '0;        altneg_next = 1'b0;
        minus_next = 1'b0;
      end else if (active) begin
        if (phase == PH_BODY) begin
          if (c == CH_STAR) begin
            do_finish  = 1'b1;
            phase_next = PH_HEX1;
          end else begin
            rxor_next = rxor ^ c;
            if (c == CH_COMMA) begin
              do_finish = 1'b1;
              if (fn != 4'd15) fn_next = fn + 4'd1;
              cif_next   = '0;
              acc_next   = '0;
              fd_next    = '0;
              pt_next    = 1'b0;
              minus_next = 1'b0;
            end else begin
              if (fn == 4'd0) begin
                if (cif < 5'd5) begin
                  if (c != nsp_name_char(1'b0, cif[2:0])) tm_next[0] = 1'b0;
                  if (c != nsp_name_char(1'b1, cif[2:0])) tm_next[1] = 1'b0;
                end else begin
                  tm_next = '0;
                end
              end else if (role == RL_TIME && cif < 5'd4) begin
                if (is_digit && cif < 5'd2) hour_next = 7'(hour * 7'd10 + 7'(dig));
                if (is_digit && cif >= 5'd2) minute_next = 7'(minute * 7'd10 + 7'(dig));
              end else if (role == RL_DATE) begin
                if (is_digit && cif < 5'd2) day_next = 7'(day * 7'd10 + 7'(dig));
                else if (is_digit && cif < 5'd4) month_next = 7'(month * 7'd10 + 7'(dig));
                else if (is_digit && cif < 5'd6) yr_next = 7'(yr * 7'd10 + 7'(dig));
              end else if (role == RL_STATUS) begin
                if (cif == 5'd0) stat_a_next = (c == CH_A);
              end else if (role == RL_NS) begin
                south_next = (cif == 5'd0) && (c == CH_S);
              end else if (role == RL_EW) begin
                west_next = (cif == 5'd0) && (c == CH_W);
              end else if (role != RL_NONE) begin
                // numeric field, saturating decimal accumulate
                if (is_digit) begin
                  if (!pt || fd < flim) begin
                    if (pt) fd_next = fd + 3'd1;
                    acc_next = (acc_step[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_step[31:0];
                  end
                end else if (c == CH_POINT) begin
                  pt_next = 1'b1;
                end else if (c == CH_MINUS && cif == 5'd0 && role == RL_SLOTB &&
                             tm == TM_GGA) begin
                  minus_next = 1'b1;
                end
              end
              if (cif != 5'd31) cif_next = cif + 5'd1;
            end
          end
        end else begin
          if (hx[4]) herr_next = 1'b1;
          rsum_next = {rsum[3:0], hx[4] ? 4'd0 : hx[3:0]};
          if (phase == PH_HEX1) begin
            phase_next = PH_HEX2;
          end else begin
            active_next = 1'b0;
            phase_next  = PH_BODY;
            emit = !herr_next && (rsum_next == rxor) && (tm == TM_RMC || tm == TM_GGA);
          end
        end
      end
    end

    // close the current field into the staged values
    if (do_finish) begin
      if (fn == 4'd0) begin
        if (cif != 5'd5) tm_next = '0;
      end else begin
        unique case (role)
          RL_TIME:  sec_next = (prod > 52'd99999) ? 17'd99999 : prod[16:0];
          RL_LAT:   lat_next = (prod > 52'd999999999) ? 30'd999999999 : prod[29:0];
          RL_LON:   lon_next = (prod > 52'd1999999999) ? 31'd1999999999 : prod[30:0];
          RL_SLOTA: sla_next = (prod > 52'd99999999) ? 27'd99999999 : prod[26:0];
          RL_SLOTB: begin
            slb_next    = (prod > 52'd99999999) ? 27'd99999999 : prod[26:0];
            altneg_next = minus;
          end
          RL_QUAL:  qual_next = (prod != 52'd0);
          RL_SATS:  sats_next = (prod > 52'd99) ? 7'd99 : prod[6:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    rec.gga          = (tm == TM_GGA);
    rec.fix          = (tm == TM_GGA) ? (qual && sats != 7'd0) : stat_a;
    rec.hour         = hour;
    rec.minute       = minute;
    rec.second_milli = sec;
    rec.south        = south;
    rec.lat_mag      = lat;
    rec.west         = west;
    rec.lon_mag      = lon;
    rec.slot_a       = sla;
    rec.slot_b_neg   = (tm == TM_GGA) && altneg;
    rec.slot_b       = slb;
    rec.day_sats     = (tm == TM_GGA) ? sats : day;
    rec.month        = (tm == TM_GGA) ? 7'd0 : month;
    rec.year2        = yr;
  end

  `NSP_ASSERT_NEVER(a_phase_needs_active, clk, rst, phase != PH_BODY && !active)
  `NSP_ASSERT_NEVER(a_phase_code, clk, rst, phase == phase_t'(2'd3))
  `NSP_ASSERT_NEXT(a_emit_ends_sentence, clk, rst, emit, !active && phase == PH_BODY)
  `NSP_ASSERT_NEVER(a_emit_from_hex2, clk, rst, emit && phase != PH_HEX2)
endmodule
`default_nettype wire

// ===== rtl/core/nsp_queue.sv =====
`default_nettype none
`include "nmea_sentence_parser_unit_assert.svh"
module nsp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire nsp_pkg::record_t wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output nsp_pkg::record_t      rdata
);
  import nsp_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  record_t       mem [QUEUE_DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == (AW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_pop) rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

  `NSP_ASSERT_NEVER(a_count_bound, clk, rst, count > (AW+1)'(QUEUE_DEPTH))
  `NSP_ASSERT_NEVER(a_push_when_full, clk, rst, push && full)
  `NSP_ASSERT_NEXT(a_push_fills, clk, rst, do_push && !do_pop, !empty)
endmodule
`default_nettype wire

// ===== rtl/core/nsp_back.sv =====
`default_nettype none
module nsp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire nsp_pkg::record_t   q_data,
  output logic                    q_pop,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    sentence_kind,
  output logic                    position_fix,
  output logic [6:0]              hour,
  output logic [6:0]              minute,
  output logic [16:0]             second_milli,
  output logic signed [30:0]      latitude,
  output logic signed [31:0]      longitude,
  output logic [26:0]             speed_or_hdop,
  output logic signed [27:0]      course_or_altitude,
  output logic [6:0]              day_or_satellites,
  output logic [6:0]              month,
  output logic [11:0]             year
);
  import nsp_pkg::*;

  logic valid;
  logic load;

  assign empty = !valid;
  assign load  = !q_empty && (!valid || pop);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (load) valid <= 1'b1;
    else if (pop) valid <= 1'b0;
  end

  // signs applied on the way out
  always_ff @(posedge clk) begin
    if (load) begin
      sentence_kind      <= q_data.gga;
      position_fix       <= q_data.fix;
      hour               <= q_data.hour;
      minute             <= q_data.minute;
      second_milli       <= q_data.second_milli;
      latitude           <= q_data.south ? -$signed({1'b0, q_data.lat_mag})
                                         : $signed({1'b0, q_data.lat_mag});
      longitude          <= q_data.west ? -$signed({1'b0, q_data.lon_mag})
                                        : $signed({1'b0, q_data.lon_mag});
      speed_or_hdop      <= q_data.slot_a;
      course_or_altitude <= q_data.slot_b_neg ? -$signed({1'b0, q_data.slot_b})
                                              : $signed({1'b0, q_data.slot_b});
      day_or_satellites  <= q_data.day_sats;
      month              <= q_data.month;
      year               <= q_data.gga ? 12'd0 : YEAR_BASE + {5'd0, q_data.year2};
    end
  end
endmodule
`default_nettype wire
